// File: design/jsld_pkg.sv
package jsld_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [2:0] KIND_DATA     = 3'd0;
	localparam logic [2:0] KIND_CLOSED   = 3'd1;
	localparam logic [2:0] KIND_NOQUOTE  = 3'd2;
	localparam logic [2:0] KIND_CTRL     = 3'd3;
	localparam logic [2:0] KIND_BADESC   = 3'd4;
	localparam logic [2:0] KIND_BADHEX   = 3'd5;
	localparam logic [2:0] KIND_EOT      = 3'd6;

	typedef struct packed {
		logic [7:0] char_in;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic [2:0] kind;
		logic       last;
	} out_item_t;

	// One queued command: a single result, or a code point to expand as UTF-8.
	typedef struct packed {
		logic [2:0]  kind;
		logic        utf;
		logic [15:0] code;
	} cmd_t;

endpackage

// File: design/json_string_literal_decoder.sv
// JSON string literal decoder.
// Input channel char_valid/char_ready/char_item carries one raw text byte per
// transfer (or an end-of-text mark); output channel res_valid/res_ready/res_item
// carries decoded bytes, the string-closed mark and error codes, with last set
// on the final result of each input byte.
// Throughput: one input byte per cycle while the queue is not full. The front
// classifier updates the escape phase and the 16-bit hex accumulator on each
// accepted byte and pushes at most one command into a QUEUE_DEPTH-entry queue.
// The back end expands each command into 1 to 3 results in an output register,
// one per cycle while the receiver keeps up. A \uXXXX escape spans six input
// bytes and yields at most three results, so the back end keeps pace and the
// queue absorbs the bursts. A transfer that yields a command writes it into the
// queue, and the output register then loads it from the queue head when free.
// Reset: phase returns to outside-awaiting-quote, accumulator clears, queue and
// output register empty.
// Receiver stall: hold the output register; the queue fills and char_ready drops
// once it is full, so no result is lost.
module json_string_literal_decoder #(
	parameter int QUEUE_DEPTH = jsld_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                char_valid,
	output logic                char_ready,
	input  jsld_pkg::in_item_t  char_item,
	output logic                res_valid,
	input  logic                res_ready,
	output jsld_pkg::out_item_t res_item
);
	import jsld_pkg::*;

	// front to queue
	logic cmd_valid;
	logic q_not_full;
	cmd_t cmd;
	// queue to back end
	logic head_valid;
	logic head_pop;
	cmd_t head_cmd;

	// Classify each byte; stall the source only when the queue is full.
	jsld_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_item  (char_item),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (q_not_full),
		.cmd        (cmd)
	);

	// Decouple the classifier from the result expansion.
	jsld_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (cmd_valid),
		.not_full   (q_not_full),
		.push_cmd   (cmd),
		.head_valid (head_valid),
		.pop        (head_pop),
		.head_cmd   (head_cmd)
	);

	// Expand each command into results; drop it once its last byte is loaded.
	jsld_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (head_pop),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_item   (res_item)
	);

endmodule

// File: design/jsld_front.sv
module jsld_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              char_valid,
	output logic              char_ready,
	input  jsld_pkg::in_item_t char_item,
	output logic              cmd_valid,
	input  logic              cmd_ready,
	output jsld_pkg::cmd_t    cmd
);
	import jsld_pkg::*;

	localparam logic [2:0] PH_OUTSIDE = 3'd0;
	localparam logic [2:0] PH_STRING  = 3'd1;
	localparam logic [2:0] PH_ESCAPE  = 3'd2;
	localparam logic [2:0] PH_HEX0    = 3'd3;
	localparam logic [2:0] PH_HEX1    = 3'd4;
	localparam logic [2:0] PH_HEX2    = 3'd5;
	localparam logic [2:0] PH_HEX3    = 3'd6;

	logic [2:0]  phase_q, phase_d;
	logic [15:0] code_q, code_d;
	logic [7:0]  c;
	logic        accept;
	logic        hex_ok;
	logic [3:0]  hex_val;
	logic        has_cmd;

	assign c          = char_item.char_in;
	assign char_ready = cmd_ready;
	assign accept     = char_valid && char_ready;
	assign cmd_valid  = accept && has_cmd;

	always_comb begin
		hex_ok  = 1'b1;
		hex_val = 4'd0;
		if (c >= "0" && c <= "9") begin
			hex_val = 4'(c - 8'h30);
		end else if (c >= "a" && c <= "f") begin
			hex_val = 4'(c - 8'h57);
		end else if (c >= "A" && c <= "F") begin
			hex_val = 4'(c - 8'h37);
		end else begin
			hex_ok = 1'b0;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		code_d   = code_q;
		has_cmd  = 1'b0;
		cmd.kind = KIND_DATA;
		cmd.utf  = 1'b0;
		cmd.code = 16'd0;
		if (char_item.end_of_text) begin
			has_cmd  = 1'b1;
			cmd.kind = KIND_EOT;
			phase_d  = PH_OUTSIDE;
		end else begin
			unique case (phase_q)
				PH_STRING: begin
					has_cmd = 1'b1;
					if (c == 8'h22) begin
						cmd.kind = KIND_CLOSED;
						phase_d  = PH_OUTSIDE;
					end else if (c < 8'h20) begin
						cmd.kind = KIND_CTRL;
						phase_d  = PH_OUTSIDE;
					end else if (c == 8'h5c) begin
						has_cmd = 1'b0;
						phase_d = PH_ESCAPE;
					end else begin
						cmd.code = {8'd0, c};
					end
				end
				PH_ESCAPE: begin
					has_cmd = 1'b1;
					phase_d = PH_STRING;
					case (c)
						8'h22, 8'h5c, 8'h2f: cmd.code = {8'd0, c};
						"b": cmd.code = 16'h0008;
						"f": cmd.code = 16'h000c;
						"n": cmd.code = 16'h000a;
						"r": cmd.code = 16'h000d;
						"t": cmd.code = 16'h0009;
						"u": begin
							has_cmd = 1'b0;
							code_d  = 16'd0;
							phase_d = PH_HEX0;
						end
						default: begin
							cmd.kind = KIND_BADESC;
							phase_d  = PH_OUTSIDE;
						end
					endcase
				end
				PH_HEX0, PH_HEX1, PH_HEX2, PH_HEX3: begin
					if (!hex_ok) begin
						has_cmd  = 1'b1;
						cmd.kind = KIND_BADHEX;
						phase_d  = PH_OUTSIDE;
					end else begin
						code_d = {code_q[11:0], hex_val};
						if (phase_q == PH_HEX3) begin
							has_cmd  = 1'b1;
							cmd.utf  = 1'b1;
							cmd.code = code_d;
							phase_d  = PH_STRING;
						end else begin
							phase_d = phase_q + 3'd1;
						end
					end
				end
				default: begin
					// outside, and the unused phase code
					if (c == 8'h22) begin
						phase_d = PH_STRING;
					end else begin
						has_cmd  = 1'b1;
						cmd.kind = KIND_NOQUOTE;
						phase_d  = PH_OUTSIDE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OUTSIDE;
			code_q  <= 16'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			code_q  <= code_d;
		end
	end

endmodule

// File: design/jsld_queue.sv
module jsld_queue #(
	parameter int DEPTH = jsld_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           not_full,
	input  jsld_pkg::cmd_t push_cmd,
	output logic           head_valid,
	input  logic           pop,
	output jsld_pkg::cmd_t head_cmd
);
	import jsld_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
	localparam logic [PW-1:0] LAST_PTR   = PW'(DEPTH - 1);

	cmd_t          slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign not_full   = (count_q != FULL_COUNT);
	assign head_valid = (count_q != '0);
	assign head_cmd   = slot_q[rd_ptr_q];
	assign do_push    = push && not_full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_COUNT)
		else $error("queue count above depth");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> not_full)
		else $error("push into full queue");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		do_push && !do_pop |=> count_q == $past(count_q) + CW'(1))
		else $error("queue count did not advance on push");
`endif

endmodule

// File: design/jsld_back.sv
module jsld_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  jsld_pkg::cmd_t      head_cmd,
	output logic                pop,
	output logic                res_valid,
	input  logic                res_ready,
	output jsld_pkg::out_item_t res_item
);
	import jsld_pkg::*;

	logic [1:0] idx_q;
	logic [1:0] len;
	logic       is_last;
	logic       load;
	logic [7:0] byte_sel;
	logic       res_valid_q;
	out_item_t  res_q;

	always_comb begin
		if (!head_cmd.utf || head_cmd.code <= 16'h007f) begin
			len = 2'd1;
		end else if (head_cmd.code <= 16'h07ff) begin
			len = 2'd2;
		end else begin
			len = 2'd3;
		end
	end

	always_comb begin
		unique case ({len, idx_q})
			{2'd2, 2'd0}: byte_sel = 8'hc0 | {3'd0, head_cmd.code[10:6]};
			{2'd2, 2'd1}: byte_sel = 8'h80 | {2'd0, head_cmd.code[5:0]};
			{2'd3, 2'd0}: byte_sel = 8'he0 | {4'd0, head_cmd.code[15:12]};
			{2'd3, 2'd1}: byte_sel = 8'h80 | {2'd0, head_cmd.code[11:6]};
			{2'd3, 2'd2}: byte_sel = 8'h80 | {2'd0, head_cmd.code[5:0]};
			default:      byte_sel = head_cmd.code[7:0];
		endcase
	end

	assign is_last   = (idx_q == len - 2'd1);
	assign load      = head_valid && (!res_valid_q || res_ready);
	assign pop       = load && is_last;
	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			res_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= is_last ? 2'd0 : idx_q + 2'd1;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q.data_byte <= byte_sel;
			res_q.kind      <= head_cmd.kind;
			res_q.last      <= is_last;
		end
	end

`ifndef SYNTHESIS
	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.kind != KIND_DATA |-> res_item.data_byte == 8'd0 && res_item.last)
		else $error("non-data result with payload or without last");
	a_mid_holds_head: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 2'd0 |-> head_valid && head_cmd.utf)
		else $error("expansion in progress without a UTF-8 head");
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 2'd3)
		else $error("byte index past three");
`endif

endmodule

// File: sim/json_string_literal_decoder_tb.sv
`timescale 1ns / 100ps

module json_string_literal_decoder_tb;
	import jsld_pkg::*;

	// Phases of the literal scanner, mirrored from the block's behavior
	typedef enum logic [2:0] {
		PH_OUTSIDE,
		PH_STRING,
		PH_ESCAPE,
		PH_HEX0,
		PH_HEX1,
		PH_HEX2,
		PH_HEX3
	} scan_phase_t;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_U      = 8'h75;

	localparam int RANDOM_ITEMS = 320;
	localparam int QUIET_ITEMS  = 100;
	localparam int IDLE_PCT     = 6;
	localparam int TAIL_CYCLES  = 8;
	localparam int LIMIT_CYCLES = 200000;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      char_valid = 1'b0;
	logic      char_ready;
	in_item_t  char_item = '0;
	logic      res_valid;
	logic      res_ready = 1'b0;
	out_item_t res_item;

	// Predictor state
	scan_phase_t scan_phase = PH_OUTSIDE;
	logic [15:0] hex_code = 16'h0000;
	out_item_t   decoded_q[$];
	out_item_t   want_item;

	int  items_sent = 0;
	int  mismatch_count = 0;
	int  cycle_count = 0;
	int  rx_hold = 0;
	bit  idle_on = 1'b1;

	logic [7:0] esc_letters [8] = '{8'h22, 8'h5c, 8'h2f, 8'h62, 8'h66, 8'h6e, 8'h72, 8'h74};
	logic [15:0] code_edges [8] = '{16'h0000, 16'h007f, 16'h0080, 16'h07ff,
		16'h0800, 16'hffff, 16'hd800, 16'hdfff};

	json_string_literal_decoder uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_item  (char_item),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_item   (res_item)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// {valid, nibble}
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		if (c >= "0" && c <= "9")
			return {1'b1, 4'(c - "0")};
		if (c >= "a" && c <= "f")
			return {1'b1, 4'(c - "a" + 8'd10)};
		if (c >= "A" && c <= "F")
			return {1'b1, 4'(c - "A" + 8'd10)};
		return 5'b0;
	endfunction

	// {valid, decoded byte} for the single-letter escapes
	function automatic logic [8:0] escape_byte(input logic [7:0] c);
		case (c)
		8'h22: return {1'b1, 8'h22};
		8'h5c: return {1'b1, 8'h5c};
		8'h2f: return {1'b1, 8'h2f};
		"b": return {1'b1, 8'h08};
		"f": return {1'b1, 8'h0c};
		"n": return {1'b1, 8'h0a};
		"r": return {1'b1, 8'h0d};
		"t": return {1'b1, 8'h09};
		default: return 9'b0;
		endcase
	endfunction

	// Nibble to a hex digit, letters in random case
	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10)
			return 8'("0") + 8'(n);
		return ($urandom_range(1) ? 8'("A") : 8'("a")) + 8'(n) - 8'd10;
	endfunction

	task automatic push_result(input logic [7:0] b, input logic [2:0] k, input logic l);
		out_item_t r;
		r.data_byte = b;
		r.kind = k;
		r.last = l;
		decoded_q = {decoded_q, r};
	endtask

	// Advance the predictor by one accepted transfer and queue what it yields
	task automatic decode_char(input logic [7:0] c, input logic eot);
		logic [4:0] hv;
		logic [8:0] ev;
		logic [15:0] cp;
		if (eot) begin
			push_result(8'h00, KIND_EOT, 1'b1);
			scan_phase = PH_OUTSIDE;
		end else begin
			case (scan_phase)
			PH_STRING: begin
				if (c == CH_QUOTE) begin
					push_result(8'h00, KIND_CLOSED, 1'b1);
					scan_phase = PH_OUTSIDE;
				end else if (c < 8'h20) begin
					push_result(8'h00, KIND_CTRL, 1'b1);
					scan_phase = PH_OUTSIDE;
				end else if (c == CH_BSLASH) begin
					scan_phase = PH_ESCAPE;
				end else begin
					push_result(c, KIND_DATA, 1'b1);
				end
			end
			PH_ESCAPE: begin
				ev = escape_byte(c);
				if (ev[8]) begin
					push_result(ev[7:0], KIND_DATA, 1'b1);
					scan_phase = PH_STRING;
				end else if (c == CH_U) begin
					hex_code = 16'h0000;
					scan_phase = PH_HEX0;
				end else begin
					push_result(8'h00, KIND_BADESC, 1'b1);
					scan_phase = PH_OUTSIDE;
				end
			end
			PH_HEX0, PH_HEX1, PH_HEX2, PH_HEX3: begin
				hv = hex_value(c);
				if (!hv[4]) begin
					push_result(8'h00, KIND_BADHEX, 1'b1);
					scan_phase = PH_OUTSIDE;
				end else begin
					hex_code = {hex_code[11:0], hv[3:0]};
					if (scan_phase == PH_HEX3) begin
						cp = hex_code;
						// Encode the code point as UTF-8, surrogates taken as is
						if (cp <= 16'h007f) begin
							push_result(cp[7:0], KIND_DATA, 1'b1);
						end else if (cp <= 16'h07ff) begin
							push_result(8'hc0 | 8'(cp >> 6), KIND_DATA, 1'b0);
							push_result(8'h80 | 8'(cp & 16'h3f), KIND_DATA, 1'b1);
						end else begin
							push_result(8'he0 | 8'((cp >> 12) & 16'h0f), KIND_DATA, 1'b0);
							push_result(8'h80 | 8'((cp >> 6) & 16'h3f), KIND_DATA, 1'b0);
							push_result(8'h80 | 8'(cp & 16'h3f), KIND_DATA, 1'b1);
						end
						scan_phase = PH_STRING;
					end else begin
						scan_phase = scan_phase_t'(scan_phase + 3'd1);
					end
				end
			end
			default: begin
				if (c == CH_QUOTE) begin
					scan_phase = PH_STRING;
				end else begin
					push_result(8'h00, KIND_NOQUOTE, 1'b1);
				end
			end
			endcase
		end
	endtask

	// Offer one byte; entered and left at a falling edge. Valid stays high
	// after the transfer so back-to-back items need no extra assignment.
	task automatic send_char(input logic [7:0] c, input logic eot);
		while (idle_on && $urandom_range(99) < IDLE_PCT) begin
			char_valid <= 1'b0;
			@(negedge clk);
		end
		char_valid <= 1'b1;
		char_item <= '{char_in: c, end_of_text: eot};
		do @(posedge clk); while (!char_ready);
		decode_char(c, eot);
		items_sent++;
		@(negedge clk);
	endtask

	// Drop valid and hold the sender until every queued result has come out
	task automatic wait_drained();
		char_valid <= 1'b0;
		while (decoded_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_directed_cases();
		// stray byte before any quote
		send_char("x", 1'b0);
		// end of text while outside; byte field must be ignored
		send_char(8'hff, 1'b1);
		// edges of plain content, \u0000, a three-byte code point, close
		send_char(CH_QUOTE, 1'b0);
		send_char(8'h20, 1'b0);
		send_char(8'hff, 1'b0);
		send_char(CH_BSLASH, 1'b0);
		send_char(CH_U, 1'b0);
		repeat (4) send_char("0", 1'b0);
		send_char(CH_BSLASH, 1'b0);
		send_char(CH_U, 1'b0);
		send_char("F", 1'b0);
		send_char("f", 1'b0);
		send_char("a", 1'b0);
		send_char("9", 1'b0);
		send_char(CH_QUOTE, 1'b0);
		// control byte inside the string
		send_char(CH_QUOTE, 1'b0);
		send_char(8'h1f, 1'b0);
		// control byte right after a backslash is a bad escape
		send_char(CH_QUOTE, 1'b0);
		send_char(CH_BSLASH, 1'b0);
		send_char(8'h00, 1'b0);
		// non-hex digit inside \u
		send_char(CH_QUOTE, 1'b0);
		send_char(CH_BSLASH, 1'b0);
		send_char(CH_U, 1'b0);
		send_char("g", 1'b0);
		wait_drained();
	endtask

	// Hold the receiver off while a long literal keeps coming, so the queue
	// fills and char_ready drops; then pause until everything is out.
	task automatic test_output_stall();
		rx_hold = 120;
		send_char(CH_QUOTE, 1'b0);
		repeat (24) send_char(8'(8'h41 + $urandom_range(0, 25)), 1'b0);
		send_char(CH_QUOTE, 1'b0);
		wait_drained();
	endtask

	// One literal with random content; when broken, one fault cuts it short
	task automatic send_random_literal(input bit broken);
		int pieces;
		int fault_at;
		int k;
		logic [7:0] c;
		logic [15:0] cp;
		pieces = $urandom_range(0, 6);
		fault_at = broken ? $urandom_range(0, pieces) : -1;
		send_char(CH_QUOTE, 1'b0);
		for (int i = 0; i <= pieces; i++) begin
			if (i == fault_at) begin
				case ($urandom_range(0, 5))
				0: send_char(8'($urandom_range(0, 255)), 1'b1);
				1: send_char(8'($urandom_range(0, 31)), 1'b0);
				2: begin
					send_char(CH_BSLASH, 1'b0);
					do c = 8'($urandom_range(0, 255));
					while (escape_byte(c) != 9'b0 || c == CH_U);
					send_char(c, 1'b0);
				end
				3: begin
					send_char(CH_BSLASH, 1'b0);
					send_char(CH_U, 1'b0);
					k = $urandom_range(0, 3);
					repeat (k) send_char(hex_char(4'($urandom_range(0, 15))), 1'b0);
					do c = 8'($urandom_range(0, 255));
					while (hex_value(c) != 5'b0);
					send_char(c, 1'b0);
				end
				4: send_char(8'($urandom_range(0, 255)), 1'b0);
				default: begin
					// text ends after a backslash or partway through \u
					send_char(CH_BSLASH, 1'b0);
					k = $urandom_range(0, 4);
					if (k > 0) begin
						send_char(CH_U, 1'b0);
						repeat (k - 1) send_char(hex_char(4'($urandom_range(0, 15))), 1'b0);
					end
					send_char(8'($urandom_range(0, 255)), 1'b1);
				end
				endcase
				return;
			end
			if (i == pieces)
				break;
			case ($urandom_range(0, 3))
			0, 1: begin
				do c = 8'($urandom_range(32, 255));
				while (c == CH_QUOTE || c == CH_BSLASH);
				send_char(c, 1'b0);
			end
			2: begin
				send_char(CH_BSLASH, 1'b0);
				send_char(esc_letters[$urandom_range(0, 7)], 1'b0);
			end
			default: begin
				case ($urandom_range(0, 3))
				0: cp = 16'($urandom_range(0, 16'h007f));
				1: cp = 16'($urandom_range(16'h0080, 16'h07ff));
				2: cp = 16'($urandom_range(16'h0800, 16'hffff));
				default: cp = code_edges[$urandom_range(0, 7)];
				endcase
				send_char(CH_BSLASH, 1'b0);
				send_char(CH_U, 1'b0);
				for (k = 3; k >= 0; k--)
					send_char(hex_char(cp[k*4 +: 4]), 1'b0);
			end
			endcase
		end
		send_char(CH_QUOTE, 1'b0);
	endtask

	// Mostly well-formed literals, some broken ones, a little raw noise;
	// the first stretch runs with no idling on either side
	task automatic test_random_literals();
		int start;
		int r;
		start = items_sent;
		idle_on = 1'b0;
		while (items_sent - start < RANDOM_ITEMS) begin
			idle_on = (items_sent - start) >= QUIET_ITEMS;
			r = $urandom_range(0, 99);
			if (r < 8)
				send_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
			else
				send_random_literal(r < 25);
		end
		idle_on = 1'b1;
	endtask

	// Receiver: random stalls, or a counted hold-off when one is requested
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			res_ready <= 1'b0;
			rx_hold = rx_hold - 1;
		end else begin
			res_ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Compare each result transfer against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (decoded_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, res_item);
				mismatch_count++;
			end else begin
				want_item = decoded_q.pop_front();
				if (res_item.data_byte !== want_item.data_byte) begin
					$display("%0t: data_byte expected %h actual %h", $time,
						want_item.data_byte, res_item.data_byte);
					mismatch_count++;
				end
				if (res_item.kind !== want_item.kind) begin
					$display("%0t: kind expected %0d actual %0d", $time,
						want_item.kind, res_item.kind);
					mismatch_count++;
				end
				if (res_item.last !== want_item.last) begin
					$display("%0t: last expected %b actual %b", $time,
						want_item.last, res_item.last);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog on the whole run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed_cases();
		test_output_stall();
		test_random_literals();
		wait_drained();
		// let any straggling result surface before the verdict
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && decoded_q.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
